[rtl/single_page_free_list_allocator_core_defines.svh]
// Assertion macros used by the allocator core.
`ifndef SINGLE_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define SINGLE_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPFLA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spfla: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SPFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spfla: next-cycle check failed");

`endif

[rtl/spfla_pkg.sv]
`default_nettype none

package spfla_pkg;

   // Width of the page fields on the ports.
   localparam int PAGE_W = 8;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_WR2,
      ST_DONE
   } state_type;

   // One response word.
   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] page;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/single_page_free_list_allocator_core.sv]
// Sequence: an accepted request passes through ST_LOOK, then ST_WR2 when the link
// memories need a second write, then ST_DONE until the output register is free.
// Requests are taken one at a time, only in ST_IDLE; the registered read of the head run
// and the single write port of each link memory set this limit.
// Reset: the head is page 0 and one run covers every page; no clearing pass is run.
`default_nettype none
`include "single_page_free_list_allocator_core_defines.svh"

module single_page_free_list_allocator_core
   import spfla_pkg::*;
#(
   parameter int PAGE_COUNT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_mode,
   input  wire logic [PAGE_W-1:0] req_page,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_ok,
   output logic      [PAGE_W-1:0] rsp_granted_page
);

   localparam int IDX_W = $clog2(PAGE_COUNT);
   localparam int LEN_W = $clog2(PAGE_COUNT + 1);

   state_type         state_ff, state_in;
   logic              mode_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              empty_ff, empty_in;

   // Entry 0 of each memory holds its reset value until first written.
   logic len0_fresh_ff, next0_fresh_ff, prev0_fresh_ff;
   logic len_fresh_rd_ff, next_fresh_rd_ff, prev_fresh_rd_ff;

   // Second write cycle, staged during the lookup.
   logic [IDX_W-1:0] wr2_next_addr_ff, wr2_next_addr_in;
   logic [IDX_W-1:0] wr2_next_data_ff, wr2_next_data_in;
   logic [IDX_W-1:0] wr2_prev_addr_ff, wr2_prev_addr_in;
   logic [IDX_W-1:0] wr2_prev_data_ff, wr2_prev_data_in;
   rsp_word_type     res_ff, res_in;

   // Memory ports.
   logic             len_we, next_we, prev_we;
   logic [IDX_W-1:0] len_wa, next_wa, prev_wa;
   logic [LEN_W-1:0] len_wd;
   logic [IDX_W-1:0] next_wd, prev_wd;
   logic [LEN_W-1:0] len_q;
   logic [IDX_W-1:0] next_q, prev_q;

   logic [LEN_W-1:0] len_rd;
   logic [IDX_W-1:0] next_rd, prev_rd;
   logic [IDX_W-1:0] h_nw, n_adj, p_adj, page_idx;
   logic [IDX_W+PAGE_W-1:0] page_wide, h_wide;
   logic             page_ok;
   logic             rsp_load, rsp_free;

   // The head run is read every cycle; the data seen in the lookup cycle
   // was read at the edge that accepted the request.
   spfla_ram #(.WIDTH(LEN_W), .DEPTH(PAGE_COUNT)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_wa),
      .wr_data (len_wd),
      .rd_addr (head_ff),
      .rd_data (len_q)
   );

   spfla_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (head_ff),
      .rd_data (next_q)
   );

   spfla_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (head_ff),
      .rd_data (prev_q)
   );

   // Read data with the reset value of entry 0 substituted.
   assign len_rd  = len_fresh_rd_ff  ? LEN_W'(PAGE_COUNT) : len_q;
   assign next_rd = next_fresh_rd_ff ? '0 : next_q;
   assign prev_rd = prev_fresh_rd_ff ? '0 : prev_q;

   // Page after the head, wrapping at the end of the pool.
   assign h_nw  = (head_ff == IDX_W'(PAGE_COUNT - 1)) ? '0 : head_ff + IDX_W'(1);
   assign n_adj = (next_rd == head_ff) ? h_nw : next_rd;
   assign p_adj = (prev_rd == head_ff) ? h_nw : prev_rd;

   // Page index of a free request, and its range check.
   assign page_wide = {{IDX_W{1'b0}}, page_ff};
   assign page_ok   = page_wide < (IDX_W + PAGE_W)'(PAGE_COUNT);
   assign page_idx  = page_wide[IDX_W-1:0];
   assign h_wide    = {{PAGE_W{1'b0}}, head_ff};

   // Sequencer: next state, memory writes and the result word.
   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      empty_in         = empty_ff;
      wr2_next_addr_in = wr2_next_addr_ff;
      wr2_next_data_in = wr2_next_data_ff;
      wr2_prev_addr_in = wr2_prev_addr_ff;
      wr2_prev_data_in = wr2_prev_data_ff;
      res_in           = res_ff;
      req_ready        = 1'b0;
      rsp_load         = 1'b0;
      len_we           = 1'b0;
      len_wa           = '0;
      len_wd           = '0;
      next_we          = 1'b0;
      next_wa          = '0;
      next_wd          = '0;
      prev_we          = 1'b0;
      prev_wa          = '0;
      prev_wd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_DONE;
            if (mode_ff == MODE_ALLOC) begin
               if (empty_ff) begin
                  res_in = '{ok: 1'b0, page: '0};
               end else begin
                  res_in = '{ok: 1'b1, page: h_wide[PAGE_W-1:0]};
                  if (len_rd > LEN_W'(1)) begin
                     // The remainder starting at the next page replaces the run.
                     next_we          = 1'b1;
                     next_wa          = p_adj;
                     next_wd          = h_nw;
                     prev_we          = 1'b1;
                     prev_wa          = n_adj;
                     prev_wd          = h_nw;
                     len_we           = 1'b1;
                     len_wa           = h_nw;
                     len_wd           = len_rd - LEN_W'(1);
                     wr2_next_addr_in = h_nw;
                     wr2_next_data_in = n_adj;
                     wr2_prev_addr_in = h_nw;
                     wr2_prev_data_in = p_adj;
                     head_in          = h_nw;
                     state_in         = ST_WR2;
                  end else if (next_rd == head_ff) begin
                     // Last free page is handed out.
                     empty_in = 1'b1;
                  end else begin
                     // Unlink a one-page run.
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = next_rd;
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = prev_rd;
                     head_in = next_rd;
                  end
               end
            end else begin
               if (!page_ok) begin
                  res_in = '{ok: 1'b0, page: '0};
               end else begin
                  res_in  = '{ok: 1'b1, page: page_ff};
                  len_we  = 1'b1;
                  len_wa  = page_idx;
                  len_wd  = LEN_W'(1);
                  next_we = 1'b1;
                  next_wa = page_idx;
                  prev_we = 1'b1;
                  prev_wa = page_idx;
                  if (empty_ff) begin
                     // The page becomes the whole list.
                     next_wd  = page_idx;
                     prev_wd  = page_idx;
                     head_in  = page_idx;
                     empty_in = 1'b0;
                  end else begin
                     // Insert the page right after the head.
                     next_wd          = next_rd;
                     prev_wd          = head_ff;
                     wr2_prev_addr_in = next_rd;
                     wr2_prev_data_in = page_idx;
                     wr2_next_addr_in = head_ff;
                     wr2_next_data_in = page_idx;
                     state_in         = ST_WR2;
                  end
               end
            end
         end
         ST_WR2: begin
            next_we  = 1'b1;
            next_wa  = wr2_next_addr_ff;
            next_wd  = wr2_next_data_ff;
            prev_we  = 1'b1;
            prev_wa  = wr2_prev_addr_ff;
            prev_wd  = wr2_prev_data_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         empty_ff       <= 1'b0;
         len0_fresh_ff  <= 1'b1;
         next0_fresh_ff <= 1'b1;
         prev0_fresh_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         empty_ff <= empty_in;
         if (len_we && len_wa == '0) begin
            len0_fresh_ff <= 1'b0;
         end
         if (next_we && next_wa == '0) begin
            next0_fresh_ff <= 1'b0;
         end
         if (prev_we && prev_wa == '0) begin
            prev0_fresh_ff <= 1'b0;
         end
      end
   end

   // Request capture, staged writes and read-side markers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         page_ff <= req_page;
      end
      wr2_next_addr_ff <= wr2_next_addr_in;
      wr2_next_data_ff <= wr2_next_data_in;
      wr2_prev_addr_ff <= wr2_prev_addr_in;
      wr2_prev_data_ff <= wr2_prev_data_in;
      res_ff           <= res_in;
      len_fresh_rd_ff  <= len0_fresh_ff && head_ff == '0;
      next_fresh_rd_ff <= next0_fresh_ff && head_ff == '0;
      prev_fresh_rd_ff <= prev0_fresh_ff && head_ff == '0;
   end

   // Output register.
   spfla_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (rsp_load),
      .word_in          (res_ff),
      .slot_free        (rsp_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_granted_page (rsp_granted_page)
   );

   // The memories are never written while the block waits for a request.
   `SPFLA_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !(len_we || next_we || prev_we))
   // A successful free always leaves the list non-empty.
   `SPFLA_ASSERT_NEXT(a_free_fills, clock, reset, state_ff == ST_LOOK && mode_ff == MODE_FREE && page_ok, !empty_ff)
   // A finished request reaches the output and the sequencer returns to idle.
   `SPFLA_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && rsp_free, rsp_valid && state_ff == ST_IDLE)

endmodule

`default_nettype wire

[rtl/spfla_ram.sv]
`default_nettype none

module spfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/spfla_rsp_reg.sv]
`default_nettype none

module spfla_rsp_reg
   import spfla_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rsp_word_type      word_in,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_ok,
   output logic      [PAGE_W-1:0] rsp_granted_page
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The slot can take a new word when empty or when its word leaves now.
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_ok           = word_ff.ok;
   assign rsp_granted_page = word_ff.page;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import spfla_pkg::*;

   localparam int POOL_PAGES   = 256;
   localparam int IDLE_PCT     = 20;
   localparam int QUEUE_AHEAD  = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic              mode;
      logic [PAGE_W-1:0] page;
   } page_req_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_mode  = MODE_ALLOC;
   logic [PAGE_W-1:0] req_page  = '0;
   logic              rsp_ready = 1'b0;
   wire               req_ready;
   wire               rsp_valid;
   wire               rsp_ok;
   wire  [PAGE_W-1:0] rsp_granted_page;

   // Shadow of the free list: run lengths and links kept at the first page of each run.
   logic [8:0]            run_len   [POOL_PAGES];
   logic [PAGE_W-1:0]     fwd_link  [POOL_PAGES];
   logic [PAGE_W-1:0]     back_link [POOL_PAGES];
   logic [PAGE_W-1:0]     head_page;
   logic                  pool_empty;
   // Pages handed out so far, and pages with a free already queued.
   logic [POOL_PAGES-1:0] page_held;
   logic [POOL_PAGES-1:0] free_queued;

   page_req_type page_req_q[$];
   rsp_word_type grant_q[$];
   page_req_type next_req;
   rsp_word_type predicted;
   rsp_word_type oldest;
   logic         req_fire = 1'b0;
   logic         steady   = 1'b0;
   int           sent_count     = 0;
   int           accepted_count = 0;
   int           mismatches     = 0;
   int           cycle_count    = 0;

   single_page_free_list_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_granted_page (rsp_granted_page)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // After reset a single run covers the whole pool, starting at page 0.
   initial begin
      for (int i = 0; i < POOL_PAGES; i++) begin
         run_len[i]   = '0;
         fwd_link[i]  = '0;
         back_link[i] = '0;
      end
      run_len[0]  = 9'(POOL_PAGES);
      head_page   = '0;
      pool_empty  = 1'b0;
      page_held   = '0;
      free_queued = '0;
   end

   // Applies one request word to the shadow list and returns the response it should give.
   task automatic apply_page_op(input logic mode, input logic [PAGE_W-1:0] page,
                                output rsp_word_type word);
      logic [PAGE_W-1:0] h;
      logic [PAGE_W-1:0] n;
      logic [PAGE_W-1:0] p;
      logic [PAGE_W-1:0] nw;
      logic [8:0]        len;
      h    = head_page;
      word = '0;
      if (mode == MODE_ALLOC) begin
         if (!pool_empty) begin
            len = run_len[h];
            n   = fwd_link[h];
            p   = back_link[h];
            if (len > 1) begin
               // The remainder of the run moves up one page and takes over as head.
               nw = h + 1'b1;
               if (n == h) begin
                  n = nw;
               end
               if (p == h) begin
                  p = nw;
               end
               fwd_link[p]   = nw;
               back_link[n]  = nw;
               run_len[nw]   = len - 1'b1;
               fwd_link[nw]  = n;
               back_link[nw] = p;
               head_page     = nw;
            end else if (n == h) begin
               // The last free page goes out and the list is left empty.
               pool_empty = 1'b1;
            end else begin
               fwd_link[p]  = n;
               back_link[n] = p;
               head_page    = n;
            end
            page_held[h] = 1'b1;
            word.ok      = 1'b1;
            word.page    = h;
         end
      end else if (int'(page) < POOL_PAGES) begin
         run_len[page] = 9'd1;
         if (pool_empty) begin
            fwd_link[page]  = page;
            back_link[page] = page;
            head_page       = page;
            pool_empty      = 1'b0;
         end else begin
            n               = fwd_link[h];
            fwd_link[page]  = n;
            back_link[page] = h;
            back_link[n]    = page;
            fwd_link[h]     = page;
         end
         page_held[page]   = 1'b0;
         free_queued[page] = 1'b0;
         word.ok           = 1'b1;
         word.page         = page;
      end
   endtask

   task automatic flag_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Request driver: a new word goes out only once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (page_req_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = page_req_q.pop_front();
            req_valid <= 1'b1;
            req_mode  <= next_req.mode;
            req_page  <= next_req.page;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         req_fire <= !reset && req_valid && req_ready;
         if (!reset && req_valid && req_ready) begin
            apply_page_op(req_mode, req_page, predicted);
            grant_q.push_back(predicted);
            accepted_count++;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               flag_mismatch("response word with nothing outstanding");
            end else begin
               oldest = grant_q.pop_front();
               if (rsp_ok !== oldest.ok) begin
                  flag_mismatch($sformatf("ok is %b, wanted %b", rsp_ok, oldest.ok));
               end
               if (rsp_granted_page !== oldest.page) begin
                  flag_mismatch($sformatf("granted_page is %0d, wanted %0d",
                                          rsp_granted_page, oldest.page));
               end
            end
         end
      end
   end

   // Keeps only a few words ahead of the driver so that free choices see fresh state.
   task automatic send_op(input logic mode, input logic [PAGE_W-1:0] page);
      while (page_req_q.size() >= QUEUE_AHEAD) @(negedge clock);
      if (mode == MODE_FREE) begin
         free_queued[page] = 1'b1;
      end
      page_req_q.push_back({mode, page});
      sent_count++;
   endtask

   // Finds a page that is out on loan and not already being returned, or -1.
   function automatic int pick_held_page();
      int start;
      int idx;
      start = $urandom_range(POOL_PAGES - 1);
      for (int i = 0; i < POOL_PAGES; i++) begin
         idx = (start + i) % POOL_PAGES;
         if (page_held[idx] && !free_queued[idx]) begin
            return idx;
         end
      end
      return -1;
   endfunction

   // A free is only ever issued for a page that is currently held.
   task automatic run_phase(input int count, input int alloc_pct, input logic no_idle);
      int pick;
      steady = no_idle;
      for (int i = 0; i < count; i++) begin
         while (page_req_q.size() >= QUEUE_AHEAD) @(negedge clock);
         pick = -1;
         if ($urandom_range(99) >= alloc_pct) begin
            pick = pick_held_page();
         end
         if (pick < 0) begin
            send_op(MODE_ALLOC, PAGE_W'($urandom()));
         end else begin
            send_op(MODE_FREE, PAGE_W'(pick));
         end
      end
      steady = 1'b0;
   endtask

   task automatic wait_quiet();
      while (accepted_count != sent_count || grant_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      while (reset) @(negedge clock);

      // Directed: carve pages off the initial run, then return some as one-page runs.
      send_op(MODE_ALLOC, 8'hFF);
      send_op(MODE_ALLOC, 8'h00);
      send_op(MODE_ALLOC, 8'hA5);
      send_op(MODE_FREE,  8'h00);
      send_op(MODE_ALLOC, 8'h5A);
      send_op(MODE_FREE,  8'h01);
      send_op(MODE_FREE,  8'h03);
      send_op(MODE_FREE,  8'h02);
      send_op(MODE_ALLOC, 8'h00);
      send_op(MODE_ALLOC, 8'hFF);
      send_op(MODE_ALLOC, 8'h0F);
      send_op(MODE_ALLOC, 8'hF0);

      // Let the block drain completely before the random traffic.
      wait_quiet();

      // Alternate draining and refilling the pool so that the empty list is reached.
      run_phase(420, 85, 1'b0);
      run_phase(420, 15, 1'b0);
      run_phase(420, 85, 1'b1);
      run_phase(480, 50, 1'b0);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
